// ===== rtl/core/ffha_pkg.sv =====
package ffha_pkg;

  localparam int HEAP_WORDS   = 1024;
  localparam int HEADER_WORDS = 1;
  localparam int TOTAL_WORDS  = HEAP_WORDS + HEADER_WORDS;
  localparam int WORD_BYTES   = 4;
  localparam int HEADER_BYTES = HEADER_WORDS * WORD_BYTES;

  localparam int ADDR_W  = 11;
  localparam int SIZE_W  = 11;
  localparam int HDR_W   = SIZE_W + 1;
  localparam int REQ_W   = 13;
  localparam int USED_W  = 13;
  localparam int LEVEL_W = 12;
  localparam int ALU_W   = 15;

  localparam logic [USED_W-1:0]  USED_MAX    = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(3072);
  localparam logic [HDR_W-1:0]   HDR_RESET   = {1'b0, SIZE_W'(HEAP_WORDS)};

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_EVAL, S_SPLIT, S_NREAD, S_NEVAL,
    S_WRITE_P, S_PREV, S_PSUB, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    ALU_ADD1, ALU_ADD_SAT, ALU_SUB_SAT
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

endpackage

// ===== rtl/core/ffha_in_if.sv =====
interface ffha_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [ffha_pkg::REQ_W-1:0]  size_bytes;
  logic [ffha_pkg::ADDR_W-1:0] address;
  modport source (output valid, kind, size_bytes, address, input ready);
  modport sink (input valid, kind, size_bytes, address, output ready);
endinterface

// ===== rtl/core/ffha_out_if.sv =====
interface ffha_out_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [ffha_pkg::ADDR_W-1:0] block_address;
  logic [ffha_pkg::USED_W-1:0] used_bytes;
  logic                        warning_raised;
  logic                        warning_cleared;
  modport source (output valid, ok, block_address, used_bytes, warning_raised,
                  warning_cleared, input ready);
  modport sink (input valid, ok, block_address, used_bytes, warning_raised,
                warning_cleared, output ready);
endinterface

// ===== rtl/core/ffha_cfg_if.sv =====
interface ffha_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ffha_pkg::LEVEL_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/ffha_ram.sv =====
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/ffha_alu.sv =====
module ffha_alu (
  input  ffha_pkg::alu_req_t         req_i,
  output logic [ffha_pkg::ALU_W-1:0] res_o
);
  import ffha_pkg::*;

  logic [ALU_W:0] sum;

  always_comb begin
    sum = {1'b0, req_i.a} + {1'b0, req_i.b};
    unique case (req_i.op)
      ALU_ADD1:    res_o = req_i.a + req_i.b + ALU_W'(1);
      ALU_ADD_SAT: res_o = (sum > (ALU_W+1)'(USED_MAX)) ? ALU_W'(USED_MAX) : sum[ALU_W-1:0];
      ALU_SUB_SAT: res_o = (req_i.b >= req_i.a) ? '0 : req_i.a - req_i.b;
      default:     res_o = '0;
    endcase
  end

endmodule

// ===== rtl/core/first_fit_heap_allocator_unit.sv =====
// First-fit heap allocator over a header-prefixed block chain.
// Words arrive on in_i: kind 0 allocates size_bytes (rounded up to whole
// 4-byte words), kind 1 releases the block whose payload starts at address.
// Each input word yields exactly one result word on out_o carrying ok, the
// allocated payload index, the used byte count and the warning events.
// cfg_i writes the 12-bit warning level and is always ready.
// An item walks the block headers one at a time through the header RAM,
// reading and then comparing each header visited, and ends with header
// writes for the split or merges; a zero-size allocate skips the walk.
// The block takes no new word while an item is in progress, but it accepts
// the next word while a finished result still waits in the output register.
// If the receiver stalls, the next item completes and holds until that
// register is free.
// Reset makes the heap one free block of 1024 words, clears the used count
// and the warning flag, and sets the warning level to 3072.
module first_fit_heap_allocator_unit (
  input  logic clk_i,
  input  logic rst_ni,
  ffha_in_if.sink    in_i,
  ffha_cfg_if.sink   cfg_i,
  ffha_out_if.source out_o
);
  import ffha_pkg::*;

  state_e state_q, state_d;

  logic                kind_q, kind_d;
  logic [11:0]         words_q, words_d;
  logic [13:0]         bytes_q, bytes_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [ADDR_W-1:0]   p_q, p_d;
  logic [ADDR_W-1:0]   prev_q, prev_d;
  logic                has_prev_q, has_prev_d;
  logic                prev_alloc_q, prev_alloc_d;
  logic [SIZE_W-1:0]   prev_size_q, prev_size_d;
  logic [11:0]         size_q, size_d;
  logic [11:0]         nx_q, nx_d;
  logic                mrg_q, mrg_d;
  logic                ok_q, ok_d;
  logic [ADDR_W-1:0]   blk_q, blk_d;
  logic [USED_W-1:0]   used_q, used_d;
  logic                flag_q, flag_d;
  logic [LEVEL_W-1:0]  level_q;
  logic                v0_q, v0_d;
  logic                rd0_q;

  logic                out_valid_q, out_valid_d;
  logic                out_ok_q, out_ok_d;
  logic [ADDR_W-1:0]   out_blk_q, out_blk_d;
  logic [USED_W-1:0]   out_used_q, out_used_d;
  logic                out_raised_q, out_raised_d;
  logic                out_cleared_q, out_cleared_d;

  logic                we;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [HDR_W-1:0]    wdata, rdata, hdr;
  logic                h_alloc;
  logic [SIZE_W-1:0]   h_size;
  logic [11:0]         h_next;
  logic [13:0]         rnd;
  logic [REQ_W-1:0]    req_b;
  alu_req_t            alu_req;
  logic [ALU_W-1:0]    alu_res;

  ffha_ram #(.WIDTH(HDR_W), .DEPTH(TOTAL_WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ffha_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign hdr     = (rd0_q && !v0_q) ? HDR_RESET : rdata;
  assign h_alloc = hdr[HDR_W-1];
  assign h_size  = hdr[SIZE_W-1:0];
  assign h_next  = 12'(p_q) + 12'(HEADER_WORDS) + 12'(h_size);

  assign in_i.ready          = (state_q == S_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign out_o.valid         = out_valid_q;
  assign out_o.ok            = out_ok_q;
  assign out_o.block_address = out_blk_q;
  assign out_o.used_bytes    = out_used_q;
  assign out_o.warning_raised  = out_raised_q;
  assign out_o.warning_cleared = out_cleared_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      flag_q      <= 1'b0;
      level_q     <= LEVEL_RESET;
      v0_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      flag_q      <= flag_d;
      v0_q        <= v0_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        level_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q        <= kind_d;
    words_q       <= words_d;
    bytes_q       <= bytes_d;
    addr_q        <= addr_d;
    p_q           <= p_d;
    prev_q        <= prev_d;
    has_prev_q    <= has_prev_d;
    prev_alloc_q  <= prev_alloc_d;
    prev_size_q   <= prev_size_d;
    size_q        <= size_d;
    nx_q          <= nx_d;
    mrg_q         <= mrg_d;
    ok_q          <= ok_d;
    blk_q         <= blk_d;
    rd0_q         <= (raddr == '0);
    out_ok_q      <= out_ok_d;
    out_blk_q     <= out_blk_d;
    out_used_q    <= out_used_d;
    out_raised_q  <= out_raised_d;
    out_cleared_q <= out_cleared_d;
  end

  always_comb begin
    state_d       = state_q;
    kind_d        = kind_q;
    words_d       = words_q;
    bytes_d       = bytes_q;
    addr_d        = addr_q;
    p_d           = p_q;
    prev_d        = prev_q;
    has_prev_d    = has_prev_q;
    prev_alloc_d  = prev_alloc_q;
    prev_size_d   = prev_size_q;
    size_d        = size_q;
    nx_d          = nx_q;
    mrg_d         = mrg_q;
    ok_d          = ok_q;
    blk_d         = blk_q;
    used_d        = used_q;
    flag_d        = flag_q;
    v0_d          = v0_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_ok_d      = out_ok_q;
    out_blk_d     = out_blk_q;
    out_used_d    = out_used_q;
    out_raised_d  = out_raised_q;
    out_cleared_d = out_cleared_q;
    we            = 1'b0;
    waddr         = p_q;
    wdata         = '0;
    raddr         = p_q;
    alu_req.op    = ALU_ADD_SAT;
    alu_req.a     = ALU_W'(used_q);
    alu_req.b     = ALU_W'(bytes_q);
    req_b         = (in_i.size_bytes < REQ_W'(WORD_BYTES)) ? REQ_W'(WORD_BYTES)
                                                           : in_i.size_bytes;
    rnd           = (14'(req_b) + 14'(WORD_BYTES - 1)) & ~14'(WORD_BYTES - 1);

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          kind_d     = in_i.kind;
          addr_d     = in_i.address;
          words_d    = 12'(rnd >> 2);
          bytes_d    = rnd + 14'(HEADER_BYTES);
          p_d        = '0;
          has_prev_d = 1'b0;
          ok_d       = 1'b0;
          blk_d      = '0;
          mrg_d      = 1'b0;
          if (!in_i.kind && in_i.size_bytes == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        if (12'(p_q) >= 12'(HEAP_WORDS)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!kind_q && !h_alloc && 12'(h_size) >= words_q) begin
          we    = 1'b1;
          ok_d  = 1'b1;
          blk_d = p_q + ADDR_W'(HEADER_WORDS);
          used_d = USED_W'(alu_res);
          nx_d   = 12'(p_q) + 12'(HEADER_WORDS) + words_q;
          size_d = 12'(h_size) - words_q - 12'(HEADER_WORDS);
          if (12'(h_size) >= words_q + 12'(HEADER_WORDS + 1)) begin
            wdata   = {1'b1, words_q[SIZE_W-1:0]};
            state_d = S_SPLIT;
          end else begin
            wdata   = {1'b1, h_size};
            state_d = S_DONE;
          end
          if (p_q == '0) begin
            v0_d = 1'b1;
          end
        end else if (kind_q && p_q + ADDR_W'(HEADER_WORDS) == addr_q) begin
          ok_d       = 1'b1;
          size_d     = 12'(h_size);
          nx_d       = h_next;
          alu_req.op = ALU_SUB_SAT;
          alu_req.b  = ALU_W'({h_size, 2'b00});
          used_d     = USED_W'(alu_res);
          if (h_next < 12'(HEAP_WORDS)) begin
            state_d = S_NREAD;
          end else begin
            state_d = S_WRITE_P;
          end
        end else begin
          prev_d       = p_q;
          has_prev_d   = 1'b1;
          prev_alloc_d = h_alloc;
          prev_size_d  = h_size;
          p_d          = h_next[ADDR_W-1:0];
          state_d      = S_READ;
        end
      end
      S_SPLIT: begin
        we      = 1'b1;
        waddr   = nx_q[ADDR_W-1:0];
        wdata   = {1'b0, size_q[SIZE_W-1:0]};
        state_d = S_DONE;
      end
      S_NREAD: begin
        raddr   = nx_q[ADDR_W-1:0];
        state_d = S_NEVAL;
      end
      S_NEVAL: begin
        if (!h_alloc) begin
          mrg_d      = 1'b1;
          alu_req.op = ALU_ADD1;
          alu_req.a  = ALU_W'(size_q);
          alu_req.b  = ALU_W'(h_size);
          size_d     = 12'(alu_res);
        end
        state_d = S_WRITE_P;
      end
      S_WRITE_P: begin
        we    = 1'b1;
        wdata = {1'b0, size_q[SIZE_W-1:0]};
        if (p_q == '0) begin
          v0_d = 1'b1;
        end
        if (mrg_q) begin
          alu_req.op = ALU_SUB_SAT;
          alu_req.b  = ALU_W'(HEADER_BYTES);
          used_d     = USED_W'(alu_res);
        end
        if (has_prev_q && !prev_alloc_q) begin
          state_d = S_PREV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_PREV: begin
        alu_req.op = ALU_ADD1;
        alu_req.a  = ALU_W'(prev_size_q);
        alu_req.b  = ALU_W'(size_q);
        we         = 1'b1;
        waddr      = prev_q;
        wdata      = {1'b0, alu_res[SIZE_W-1:0]};
        if (prev_q == '0) begin
          v0_d = 1'b1;
        end
        state_d = S_PSUB;
      end
      S_PSUB: begin
        alu_req.op = ALU_SUB_SAT;
        alu_req.b  = ALU_W'(HEADER_BYTES);
        used_d     = USED_W'(alu_res);
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d   = 1'b1;
          out_ok_d      = ok_q;
          out_blk_d     = kind_q ? '0 : blk_q;
          out_used_d    = used_q;
          out_raised_d  = !kind_q && ok_q && !flag_q && used_q > USED_W'(level_q);
          out_cleared_d = kind_q && ok_q && flag_q && used_q < USED_W'(level_q);
          if (out_raised_d) begin
            flag_d = 1'b1;
          end
          if (out_cleared_d) begin
            flag_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !we) else $error("header write while idle");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ok_q |-> out_blk_q == '0) else $error("failed item with address");

  a_raise_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flag_q) |-> out_raised_q && out_valid_q) else $error("flag set without event");

  a_clear_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(flag_q) |-> out_cleared_q && out_valid_q) else $error("flag cleared without event");

endmodule
